>>> hw/rtl/sdre_pkg.sv
// ----------------------------------------------------------------------------
// sdre_pkg
// shared constants, state encoding and controller/datapath interface types
// for the signed radix digit emitter
// ----------------------------------------------------------------------------
package sdre_pkg;

  localparam int MAX_RADIX   = 16;
  localparam int VALUE_BITS  = 32;
  localparam int SYM_W       = 8;
  localparam int CFG_W       = 64;
  localparam int SYMS_PER_REG = CFG_W / SYM_W;
  localparam int BASE_W      = 5;
  localparam int DIGIT_W     = $clog2(MAX_RADIX);
  localparam int ADDR_W      = $clog2(VALUE_BITS);
  localparam int BITCNT_W    = $clog2(VALUE_BITS);
  localparam int COUNT_W     = $clog2(VALUE_BITS + 1);
  localparam int REG_INDEX_W = 2;

  localparam logic [REG_INDEX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_BASE_SIZE    = 2'd2;

  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_STORE,
    ST_SIGN,
    ST_FETCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic store_digit;
    logic emit_sign;
    logic fetch;
    logic emit_digit;
  } dp_cmd_t;

  typedef struct packed {
    logic alpha_ok;
    logic negative;
    logic div_last;
    logic quot_zero;
    logic store_full;
    logic last_digit;
  } dp_status_t;

endpackage

>>> hw/rtl/signed_radix_digit_emitter_top.sv
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_top
// writes a signed 32-bit value as text in a configurable radix and alphabet
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. The
// alphabet (symbols_low, symbols_high, base_size) is checked first: a size
// below 2 or above 16, a zero, '+' or '-' symbol, or a repeated symbol gives
// no output at all and busy drops once the check state is left. Otherwise the
// block emits a '-' for a negative value, then the digit symbols most
// significant first, the last one flagged by last. Each symbol is shown for
// exactly one cycle with strobe high; the receiver cannot hold it off, so it
// must take every strobed symbol. The most negative value converts exactly.
// Each digit comes from the one-bit-per-cycle restoring divider, its quotient
// bits followed by a store step, and each output digit passes through a digit
// store read and then the output register. Configuration writes must only
// happen while busy is low and no symbols are still due.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter_top (
  input  logic                                   clk,
  input  logic                                   rst,
  // request channel
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [sdre_pkg::VALUE_BITS-1:0] value,
  // configuration write port
  input  logic                                   write_enable,
  input  logic [sdre_pkg::REG_INDEX_W-1:0]       reg_index,
  input  logic [sdre_pkg::CFG_W-1:0]             write_data,
  // result channel
  output logic                                   strobe,
  output logic [sdre_pkg::SYM_W-1:0]             symbol,
  output logic                                   last
);
  import sdre_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: owns the state, drives one command set per cycle
  sdre_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // config registers, divider, digit store and output register
  sdre_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .value        (value),
    .cmd          (cmd),
    .status       (status),
    .strobe       (strobe),
    .symbol       (symbol),
    .last         (last)
  );

endmodule

>>> hw/rtl/sdre_ctrl.sv
// ----------------------------------------------------------------------------
// sdre_ctrl
// sequencer: alphabet check, digit-by-digit division, sign and digit output
// ----------------------------------------------------------------------------
module sdre_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  sdre_pkg::dp_status_t status,
  output sdre_pkg::dp_cmd_t    cmd,
  output logic                busy
);
  import sdre_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = status.alpha_ok ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store_digit = 1'b1;
        if (status.quot_zero || status.store_full) begin
          state_next = status.negative ? ST_SIGN : ST_FETCH;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_next    = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_digit = 1'b1;
        state_next     = status.last_digit ? ST_IDLE : ST_FETCH;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/sdre_datapath.sv
// ----------------------------------------------------------------------------
// sdre_datapath
// config registers, alphabet check, restoring divider, digit store, output
// ----------------------------------------------------------------------------
module sdre_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   write_enable,
  input  logic [sdre_pkg::REG_INDEX_W-1:0]       reg_index,
  input  logic [sdre_pkg::CFG_W-1:0]             write_data,
  input  logic signed [sdre_pkg::VALUE_BITS-1:0] value,
  input  sdre_pkg::dp_cmd_t                      cmd,
  output sdre_pkg::dp_status_t                   status,
  output logic                                   strobe,
  output logic [sdre_pkg::SYM_W-1:0]             symbol,
  output logic                                   last
);
  import sdre_pkg::*;

  logic [CFG_W-1:0]      symbols_low;
  logic [CFG_W-1:0]      symbols_high;
  logic [BASE_W-1:0]     base_size;

  logic [VALUE_BITS-1:0] mag;
  logic                  negative;
  logic [DIGIT_W-1:0]    rem;
  logic [BITCNT_W-1:0]   bitcnt;
  logic [COUNT_W-1:0]    count;
  logic [DIGIT_W-1:0]    digit_store [VALUE_BITS];
  logic [DIGIT_W-1:0]    rdata;

  logic [SYM_W-1:0]      sym [MAX_RADIX];
  logic                  alpha_ok;
  logic [DIGIT_W:0]      partial;
  logic [DIGIT_W:0]      diff;
  logic                  ge;

  // alphabet view of the two symbol registers
  always_comb begin
    for (int i = 0; i < MAX_RADIX; i++) begin
      if (i < SYMS_PER_REG) begin
        sym[i] = symbols_low[i*SYM_W +: SYM_W];
      end else begin
        sym[i] = symbols_high[(i-SYMS_PER_REG)*SYM_W +: SYM_W];
      end
    end
  end

  // base size 2 to 16; symbols in use: none zero, '+' or '-', and no repeats
  always_comb begin
    alpha_ok = (base_size >= BASE_W'(2)) && (base_size <= BASE_W'(MAX_RADIX));
    for (int i = 0; i < MAX_RADIX; i++) begin
      if (BASE_W'(i) < base_size) begin
        if (sym[i] == '0 || sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS) begin
          alpha_ok = 1'b0;
        end
        for (int j = 0; j < i; j++) begin
          if (sym[j] == sym[i]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  // one quotient bit per cycle
  assign partial = {rem, mag[VALUE_BITS-1]};
  assign diff    = partial - (DIGIT_W+1)'(base_size);
  assign ge      = (partial >= (DIGIT_W+1)'(base_size));

  always_ff @(posedge clk) begin
    if (rst) begin
      symbols_low  <= '0;
      symbols_high <= '0;
      base_size    <= '0;
    end else if (write_enable) begin
      case (reg_index)
        REG_SYMBOLS_LOW:  symbols_low  <= write_data;
        REG_SYMBOLS_HIGH: symbols_high <= write_data;
        REG_BASE_SIZE:    base_size    <= write_data[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      negative <= value[VALUE_BITS-1];
      mag      <= value[VALUE_BITS-1] ? (~value + 1'b1) : value;
      count    <= '0;
      rem      <= '0;
      bitcnt   <= BITCNT_W'(VALUE_BITS - 1);
    end
    if (cmd.div_step) begin
      rem    <= ge ? diff[DIGIT_W-1:0] : partial[DIGIT_W-1:0];
      mag    <= {mag[VALUE_BITS-2:0], ge};
      bitcnt <= bitcnt - 1'b1;
    end
    if (cmd.store_digit) begin
      digit_store[count[ADDR_W-1:0]] <= rem;
      count  <= count + 1'b1;
      rem    <= '0;
      bitcnt <= BITCNT_W'(VALUE_BITS - 1);
    end
    if (cmd.fetch) begin
      rdata <= digit_store[ADDR_W'(count - 1'b1)];
    end
    if (cmd.emit_digit) begin
      count <= count - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign | cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      symbol <= CHAR_MINUS;
      last   <= 1'b0;
    end else if (cmd.emit_digit) begin
      symbol <= sym[rdata];
      last   <= (count == COUNT_W'(1));
    end
  end

  always_comb begin
    status.alpha_ok   = alpha_ok;
    status.negative   = negative;
    status.div_last   = (bitcnt == '0);
    status.quot_zero  = (mag == '0);
    status.store_full = (count == COUNT_W'(VALUE_BITS - 1));
    status.last_digit = (count == COUNT_W'(1));
  end

endmodule
